// ----- design/lru_bucket_hash_table_assert.svh -----
// Assertion macros used by the table's top module.
`ifndef LRU_BUCKET_HASH_TABLE_ASSERT_SVH
`define LRU_BUCKET_HASH_TABLE_ASSERT_SVH
`ifndef SYNTHESIS
`define LBHT_ASSERT(label, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("lbht assertion failed");
`define LBHT_IMPLY_NEXT(label, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("lbht assertion failed");
`else
`define LBHT_ASSERT(label, expr)
`define LBHT_IMPLY_NEXT(label, cond, expr)
`endif
`endif

// ----- design/lbht_pkg.sv -----
// Types and constants of the set-associative table.
`timescale 1ns / 1ps
package lbht_pkg;
    localparam int NUM_SETS   = 256;
    localparam int WAYS       = 8;
    localparam int KEY_WIDTH  = 32;
    localparam int DATA_WIDTH = 32;
    localparam int SET_W      = (NUM_SETS > 1) ? $clog2(NUM_SETS) : 1;
    localparam int IDX_W      = (WAYS > 1) ? $clog2(WAYS) : 1;
    localparam int CNT_W      = $clog2(WAYS + 1);

    typedef struct packed {
        logic [KEY_WIDTH-1:0]  key;
        logic [DATA_WIDTH-1:0] data;
    } entry_t;

    typedef entry_t [WAYS-1:0] row_t;

    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_op_t;

    typedef enum logic [1:0] {
        CMD_FIND,
        CMD_INSERT,
        CMD_REMOVE,
        CMD_REKEY
    } cmd_t;

    typedef enum logic [1:0] {
        STAT_OK,
        STAT_MISS,
        STAT_PRESENT,
        STAT_UNUSED
    } status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_EXEC,
        ST_WRITE,
        ST_READ2,
        ST_DONE
    } state_t;

    typedef struct packed {
        logic             rd_en;
        logic [SET_W-1:0] rd_addr;
        logic             wr_en;
        logic [SET_W-1:0] wr_addr;
        logic [CNT_W-1:0] wr_cnt;
    } store_ctrl_t;
endpackage

// ----- design/lbht_cell.sv -----
// One slot of the working set: holds an entry and compares its key.
`timescale 1ns / 1ps
module lbht_cell (
    input  logic                          clk,
    input  lbht_pkg::cell_op_t            op,
    input  lbht_pkg::entry_t              load_entry,
    input  lbht_pkg::entry_t              left_entry,
    input  lbht_pkg::entry_t              right_entry,
    input  logic [lbht_pkg::KEY_WIDTH-1:0] cmp_key,
    output lbht_pkg::entry_t              entry,
    output logic                          match
);
    import lbht_pkg::*;

    entry_t entry_reg;
    entry_t entry_next;

    always_comb
    begin
        case (op)
            CELL_LOAD:       entry_next = load_entry;
            CELL_FROM_LEFT:  entry_next = left_entry;
            CELL_FROM_RIGHT: entry_next = right_entry;
            default:         entry_next = entry_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    assign entry = entry_reg;
    assign match = (entry_reg.key == cmp_key);
endmodule

// ----- design/lbht_store.sv -----
// Set storage: one row of entries per set, plus the per-set entry counts.
`timescale 1ns / 1ps
module lbht_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lbht_pkg::store_ctrl_t ctrl,
    input  lbht_pkg::row_t        wr_row,
    output lbht_pkg::row_t        rd_row,
    output logic [lbht_pkg::CNT_W-1:0] rd_cnt
);
    import lbht_pkg::*;

    row_t             row_mem [NUM_SETS];
    logic [CNT_W-1:0] cnt_mem [NUM_SETS];
    logic [NUM_SETS-1:0] valid_reg;
    row_t             rd_row_reg;
    logic [CNT_W-1:0] rd_cnt_reg;

    always_ff @(posedge clk)
    begin
        if (ctrl.wr_en)
        begin
            row_mem[ctrl.wr_addr] <= wr_row;
            cnt_mem[ctrl.wr_addr] <= ctrl.wr_cnt;
        end
        if (ctrl.rd_en)
        begin
            rd_row_reg <= row_mem[ctrl.rd_addr];
            rd_cnt_reg <= cnt_mem[ctrl.rd_addr];
        end
    end

    // A set never written reads as empty.
    logic rd_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (ctrl.wr_en)
                valid_reg[ctrl.wr_addr] <= 1'b1;
            if (ctrl.rd_en)
                rd_valid_reg <= valid_reg[ctrl.rd_addr];
        end
    end

    assign rd_row = rd_row_reg;
    assign rd_cnt = rd_valid_reg ? rd_cnt_reg : '0;
endmodule

// ----- design/lru_bucket_hash_table.sv -----
// Top level of the set-associative key/data table with most-recent-first order.
`timescale 1ns / 1ps
// One item runs a find, insert, remove or rekey command on one set of up to
// eight entries. The set is read from the row memory into a chain of cells,
// reordered there by shifting entries between neighbours, and written back.
// A miss of a find, remove or rekey writes nothing back; a rekey hit also
// reads and writes a second set. A new item is taken once the previous one
// has left the cells, while its result may still wait at the output.
module lru_bucket_hash_table (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          cfg_valid,
    output logic          cfg_ready,
    input  logic [3:0]    cfg_data,      // entry_limit
    input  logic          s_tvalid,
    output logic          s_tready,
    // key, set_index, data_in, new_key, new_set_index
    input  logic [111:0]  s_tdata,
    input  logic [1:0]    s_tuser,       // command
    output logic          m_tvalid,
    input  logic          m_tready,
    output logic [95:0]   m_tdata,       // data_out, evicted_key, evicted_data
    output logic [2:0]    m_tuser        // status, evicted
);
    import lbht_pkg::*;
    `include "lru_bucket_hash_table_assert.svh"

    state_t state_reg, state_next;
    logic [3:0] limit_reg;
    logic [1:0] cmd_reg;
    logic [KEY_WIDTH-1:0] key_reg, nkey_reg;
    logic [DATA_WIDTH-1:0] data_reg, keep_reg, keep_next;
    logic [SET_W-1:0] set_reg, nset_reg;
    logic phase2_reg, phase2_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    status_t res_status_reg, res_status_next;
    logic [DATA_WIDTH-1:0] res_data_reg, res_data_next;
    logic res_ev_reg, res_ev_next;
    entry_t res_eve_reg, res_eve_next;
    logic out_valid_reg;
    logic [95:0] out_data_reg;
    logic [2:0] out_user_reg;

    store_ctrl_t ctrl;
    row_t rd_row, cells;
    logic [CNT_W-1:0] rd_cnt;
    cell_op_t [WAYS-1:0] ops;
    logic [WAYS-1:0] match;
    entry_t front;
    logic [KEY_WIDTH-1:0] cmp_key;

    logic accept;
    assign accept    = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;

    lbht_store u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (ctrl),
        .wr_row (cells),
        .rd_row (rd_row),
        .rd_cnt (rd_cnt)
    );

    assign cmp_key = key_reg;

    for (genvar i = 0; i < WAYS; i++)
    begin : g_cell
        lbht_cell u_cell (
            .clk         (clk),
            .op          (ops[i]),
            .load_entry  (rd_row[i]),
            .left_entry  ((i == 0) ? front : cells[(i == 0) ? 0 : i - 1]),
            .right_entry (cells[(i == WAYS - 1) ? i : i + 1]),
            .cmp_key     (cmp_key),
            .entry       (cells[i]),
            .match       (match[i])
        );
    end

    // Effective limit: zero acts as one, anything above the way count as the way count.
    logic [CNT_W-1:0] lim;
    always_comb
    begin
        if (limit_reg == 4'd0)
            lim = CNT_W'(1);
        else if (32'(limit_reg) > WAYS)
            lim = CNT_W'(WAYS);
        else
            lim = CNT_W'(limit_reg);
    end

    logic hit;
    logic [IDX_W-1:0] pos;
    always_comb
    begin
        hit = 1'b0;
        pos = '0;
        for (int i = WAYS - 1; i >= 0; i--)
        begin
            if (match[i] && (CNT_W'(i) < cnt_reg))
            begin
                hit = 1'b1;
                pos = IDX_W'(i);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            limit_reg     <= 4'd8;
            phase2_reg    <= 1'b0;
            cnt_reg       <= '0;
            res_ev_reg    <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            phase2_reg <= phase2_next;
            cnt_reg    <= cnt_next;
            res_ev_reg <= res_ev_next;
            if (cfg_valid && cfg_ready)
                limit_reg <= cfg_data;
            if (state_reg == ST_DONE && (!out_valid_reg || m_tready))
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            cmd_reg  <= s_tuser;
            key_reg  <= s_tdata[31:0];
            set_reg  <= SET_W'(s_tdata[39:32]);
            data_reg <= s_tdata[71:40];
            nkey_reg <= s_tdata[103:72];
            nset_reg <= SET_W'(s_tdata[111:104]);
        end
        keep_reg       <= keep_next;
        res_status_reg <= res_status_next;
        res_data_reg   <= res_data_next;
        res_eve_reg    <= res_eve_next;
        if (state_reg == ST_DONE && (!out_valid_reg || m_tready))
        begin
            out_data_reg <= {res_eve_reg.data, res_eve_reg.key, res_data_reg};
            out_user_reg <= {res_ev_reg, res_status_reg};
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        phase2_next     = phase2_reg;
        cnt_next        = cnt_reg;
        keep_next       = keep_reg;
        res_status_next = res_status_reg;
        res_data_next   = res_data_reg;
        res_ev_next     = res_ev_reg;
        res_eve_next    = res_eve_reg;
        ops             = {WAYS{CELL_HOLD}};
        front           = cells[pos];
        ctrl            = '0;
        ctrl.wr_addr    = phase2_reg ? nset_reg : set_reg;
        ctrl.wr_cnt     = cnt_reg;

        case (state_reg)
            ST_IDLE:
            begin
                ctrl.rd_addr = SET_W'(s_tdata[39:32]);
                if (accept)
                begin
                    ctrl.rd_en      = 1'b1;
                    phase2_next     = 1'b0;
                    res_status_next = STAT_OK;
                    res_data_next   = '0;
                    res_ev_next     = 1'b0;
                    res_eve_next    = '0;
                    state_next      = ST_LOAD;
                end
            end
            ST_LOAD:
            begin
                ops        = {WAYS{CELL_LOAD}};
                cnt_next   = rd_cnt;
                state_next = ST_EXEC;
            end
            ST_EXEC:
            begin
                state_next = ST_WRITE;
                if (phase2_reg || (!hit && cmd_reg == CMD_INSERT))
                begin
                    // Place a new entry at the front, dropping the oldest of a full set.
                    front.key  = phase2_reg ? nkey_reg : key_reg;
                    front.data = phase2_reg ? keep_reg : data_reg;
                    ops        = {WAYS{CELL_FROM_LEFT}};
                    if (cnt_reg >= lim)
                    begin
                        res_ev_next  = 1'b1;
                        res_eve_next = cells[IDX_W'(cnt_reg - CNT_W'(1))];
                        cnt_next     = lim;
                    end
                    else
                        cnt_next = cnt_reg + CNT_W'(1);
                end
                else if (!hit)
                begin
                    res_status_next = STAT_MISS;
                    state_next      = ST_DONE;
                end
                else if (cmd_reg == CMD_FIND || cmd_reg == CMD_INSERT)
                begin
                    if (cmd_reg == CMD_FIND)
                        res_data_next = cells[pos].data;
                    else
                        res_status_next = STAT_PRESENT;
                    for (int i = 0; i < WAYS; i++)
                        if (IDX_W'(i) <= pos)
                            ops[i] = CELL_FROM_LEFT;
                end
                else
                begin
                    keep_next = cells[pos].data;
                    cnt_next  = cnt_reg - CNT_W'(1);
                    for (int i = 0; i < WAYS; i++)
                        if (IDX_W'(i) >= pos)
                            ops[i] = CELL_FROM_RIGHT;
                end
            end
            ST_WRITE:
            begin
                ctrl.wr_en = 1'b1;
                if (cmd_reg == CMD_REKEY && !phase2_reg)
                begin
                    phase2_next = 1'b1;
                    state_next  = ST_READ2;
                end
                else
                    state_next = ST_DONE;
            end
            ST_READ2:
            begin
                ctrl.rd_en   = 1'b1;
                ctrl.rd_addr = nset_reg;
                state_next   = ST_LOAD;
            end
            ST_DONE:
            begin
                if (!out_valid_reg || m_tready)
                    state_next = ST_IDLE;
            end
            default:
                state_next = ST_IDLE;
        endcase
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;
    assign m_tuser  = out_user_reg;

    `LBHT_ASSERT(a_cnt_range, 32'(cnt_reg) <= WAYS)
    `LBHT_IMPLY_NEXT(a_accept_loads, accept, state_reg == ST_LOAD)
    `LBHT_ASSERT(a_evict_ok, !res_ev_reg || res_status_reg == STAT_OK)
    `LBHT_IMPLY_NEXT(a_phase2_rekey, state_reg == ST_READ2, phase2_reg && cmd_reg == CMD_REKEY)
endmodule
